// ===== design/periodic_duplicate_atom_detector_top_defines.svh =====
// Assertion macros shared by the duplicate atom detector modules.
// Depends on nothing; expects aclk and aresetn in the scope of each use.
`ifndef PERIODIC_DUPLICATE_ATOM_DETECTOR_TOP_DEFINES_SVH
`define PERIODIC_DUPLICATE_ATOM_DETECTOR_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PDAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PDAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pdad_pkg.sv =====
// Shared types and constants of the duplicate atom detector.
// Used by the controller, the datapath and the top level.
package pdad_pkg;

    localparam int TYPE_BITS     = 8;
    localparam int POS_BITS      = 16;
    localparam int TOL_BITS      = 32;
    localparam int INDEX_BITS    = 8;
    localparam int MAX_ATOMS_DEF = 256;
    localparam int ENTRY_BITS    = TYPE_BITS + 3 * POS_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take in a new atom
        logic issue;    // read the next table entry
        logic finish;   // store the atom and load the result
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // every valid entry has been read
        logic pipe_busy;  // compares still in flight
    } dp_stat_t;

endpackage

// ===== design/periodic_duplicate_atom_detector_top.sv =====
// Top level of the periodic duplicate atom detector.
// Depends on pdad_pkg, pdad_ctrl, pdad_datapath and pdad_ram.
//
// Use:
//   Atoms enter on the s_ stream, one item per handshake; each item returns
//   exactly one result item on the m_ stream, in order.
//   Write tolerance_sq (unsigned Q0.32) through cfg_we / cfg_wdata while idle.
//   Set s_tuser (start of set) to empty the table before the atom is checked.
// Scan:
//   An atom arriving with N entries in the table is compared against them
//   one entry per cycle through the table RAM read port; the block takes the
//   next atom only once the result of the last one is loaded into the output
//   register.
// Reset:
//   aresetn low clears the entry count, the tolerance and the handshakes.
//   The table needs no clearing pass; only stored entries are ever read.
// Stall:
//   A result waits in the output register until m_tready; meanwhile the
//   next atom is accepted and scanned, and waits at its end for the slot.
module periodic_duplicate_atom_detector_top
    import pdad_pkg::*;
#(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // tolerance register
    input  logic                cfg_we,
    input  logic [TOL_BITS-1:0] cfg_wdata,
    // atom stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [55:0]         s_tdata,   // atom_type, pos_x, pos_y, pos_z
    input  logic [0:0]          s_tuser,   // start_of_set
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // match_index, stored_index
    output logic [1:0]          m_tuser    // is_duplicate, overflow
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    logic                  out_dup, out_ovf;
    logic [INDEX_BITS-1:0] out_match, out_stored;

    // Sequence each atom: accept, scan the table, drain, store and report.
    pdad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Unpack the atom fields from the lowest bit up.
    pdad_datapath #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_start   (s_tuser[0]),
        .in_type    (s_tdata[TYPE_BITS-1:0]),
        .in_x       (s_tdata[TYPE_BITS +: POS_BITS]),
        .in_y       (s_tdata[TYPE_BITS + POS_BITS +: POS_BITS]),
        .in_z       (s_tdata[TYPE_BITS + 2 * POS_BITS +: POS_BITS]),
        .cmd        (cmd),
        .stat       (stat),
        .out_dup    (out_dup),
        .out_ovf    (out_ovf),
        .out_match  (out_match),
        .out_stored (out_stored)
    );

    assign m_tdata = {out_stored, out_match};
    assign m_tuser = {out_ovf, out_dup};

endmodule

// ===== design/pdad_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/pdad_ctrl.sv =====
// Sequencer of the duplicate atom detector: handshakes and scan control.
// Depends on pdad_pkg and the assertion macro header.
`include "periodic_duplicate_atom_detector_top_defines.svh"

module pdad_ctrl
    import pdad_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.issue  = (state_reg == ST_SCAN) && !stat.scan_done;
        cmd.finish = (state_reg == ST_FINISH) && out_free;
    end

    // Hold the result until taken; a new one only lands in a free slot.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `PDAD_ASSERT_NOW(a_finish_slot_free, cmd.finish, !m_tvalid_reg || m_tready, "result overwritten")
    `PDAD_ASSERT_NEXT(a_load_starts_scan, cmd.load, state_reg == ST_SCAN, "accept did not start scan")
    `PDAD_ASSERT_NEXT(a_drain_exit, (state_reg == ST_DRAIN) && !stat.pipe_busy, state_reg == ST_FINISH, "drain stuck")

endmodule

// ===== design/pdad_datapath.sv =====
// Datapath of the duplicate atom detector: atom table, distance pipeline,
// match tracking and result register. Depends on pdad_pkg, pdad_ram, macros.
`include "periodic_duplicate_atom_detector_top_defines.svh"

module pdad_datapath
    import pdad_pkg::*;
#(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [TOL_BITS-1:0]   cfg_wdata,
    input  logic                  in_start,
    input  logic [TYPE_BITS-1:0]  in_type,
    input  logic [POS_BITS-1:0]   in_x,
    input  logic [POS_BITS-1:0]   in_y,
    input  logic [POS_BITS-1:0]   in_z,
    input  ctl_cmd_t              cmd,
    output dp_stat_t              stat,
    output logic                  out_dup,
    output logic                  out_ovf,
    output logic [INDEX_BITS-1:0] out_match,
    output logic [INDEX_BITS-1:0] out_stored
);

    localparam int IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W = $clog2(MAX_ATOMS + 1);
    localparam int SQ_W  = 2 * POS_BITS;
    localparam int SUM_W = SQ_W + 2;

    // Magnitude of the difference taken modulo one, read as signed.
    function automatic logic [POS_BITS-1:0] wrap_mag(input logic [POS_BITS-1:0] a,
                                                     input logic [POS_BITS-1:0] b);
        logic [POS_BITS-1:0] d;
        d = a - b;
        return d[POS_BITS-1] ? (~d + 1'b1) : d;
    endfunction

    logic [TOL_BITS-1:0]  tol_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg;
    logic [TYPE_BITS-1:0] type_reg;
    logic [POS_BITS-1:0]  x_reg, y_reg, z_reg;

    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [ENTRY_BITS-1:0] rd_data;
    logic [TYPE_BITS-1:0] e_type;
    logic [POS_BITS-1:0]  e_x, e_y, e_z;
    logic [POS_BITS-1:0]  mag_x, mag_y, mag_z;

    logic                 sq_valid_reg;
    logic                 type_eq_reg;
    logic [IDX_W-1:0]     sq_idx_reg;
    logic [SQ_W-1:0]      sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SUM_W-1:0]     sum;
    logic                 hit;

    logic                 dup_reg;
    logic [IDX_W-1:0]     match_reg;
    logic                 room;
    logic                 out_dup_reg, out_ovf_reg;
    logic [INDEX_BITS-1:0] out_match_reg, out_stored_reg;
    logic [IDX_W+INDEX_BITS-1:0] match_wide;
    logic [CNT_W+INDEX_BITS-1:0] count_wide;

    assign room = count_reg < CNT_W'(MAX_ATOMS);

    // Table: type in the low bits, then x, y, z.
    pdad_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ATOMS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.finish && room),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({z_reg, y_reg, x_reg, type_reg}),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign {e_z, e_y, e_x, e_type} = rd_data;
    assign mag_x = wrap_mag(e_x, x_reg);
    assign mag_y = wrap_mag(e_y, y_reg);
    assign mag_z = wrap_mag(e_z, z_reg);

    assign sum = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);
    assign hit = sq_valid_reg && type_eq_reg && (sum < SUM_W'(tol_reg));

    always_comb begin
        count_next = count_reg;
        if (cmd.load && in_start) begin
            count_next = '0;
        end else if (cmd.finish && room) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg      <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            count_reg    <= count_next;
            rd_valid_reg <= cmd.issue;
            sq_valid_reg <= rd_valid_reg;
        end
    end

    // Atom under test, scan index and first match.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            type_reg <= in_type;
            x_reg    <= in_x;
            y_reg    <= in_y;
            z_reg    <= in_z;
            idx_reg  <= '0;
            dup_reg  <= 1'b0;
            match_reg <= '0;
        end else begin
            if (cmd.issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (hit && !dup_reg) begin
                dup_reg   <= 1'b1;
                match_reg <= sq_idx_reg;
            end
        end
        rd_idx_reg  <= idx_reg[IDX_W-1:0];
        sq_idx_reg  <= rd_idx_reg;
        type_eq_reg <= (e_type == type_reg);
        sq_x_reg    <= SQ_W'(mag_x) * SQ_W'(mag_x);
        sq_y_reg    <= SQ_W'(mag_y) * SQ_W'(mag_y);
        sq_z_reg    <= SQ_W'(mag_z) * SQ_W'(mag_z);
    end

    assign match_wide = {{INDEX_BITS{1'b0}}, match_reg};
    assign count_wide = {{INDEX_BITS{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_dup_reg    <= dup_reg;
            out_match_reg  <= match_wide[INDEX_BITS-1:0];
            out_ovf_reg    <= !room;
            out_stored_reg <= room ? count_wide[INDEX_BITS-1:0] : '0;
        end
    end

    assign stat.scan_done = (idx_reg == count_reg);
    assign stat.pipe_busy = rd_valid_reg || sq_valid_reg;

    assign out_dup    = out_dup_reg;
    assign out_ovf    = out_ovf_reg;
    assign out_match  = out_match_reg;
    assign out_stored = out_stored_reg;

    `PDAD_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ATOMS), "entry count too large")
    `PDAD_ASSERT_NEXT(a_start_clears, cmd.load && in_start, count_reg == '0, "start did not empty table")
    `PDAD_ASSERT_NEXT(a_store_advances, cmd.finish && room && !cmd.load, count_reg == $past(count_reg) + 1'b1, "store did not advance count")

endmodule

// ===== test/periodic_duplicate_atom_detector_top_test.sv =====
// Self-checking test of the periodic duplicate atom detector top level.
// Depends on pdad_pkg and periodic_duplicate_atom_detector_top; feeds atom items,
// predicts each result in a local table model and checks results in order.
`timescale 1ns / 1ps

module periodic_duplicate_atom_detector_top_test;
    import pdad_pkg::*;

    typedef struct packed {
        logic                 start;
        logic [TYPE_BITS-1:0] species;
        logic [POS_BITS-1:0]  x;
        logic [POS_BITS-1:0]  y;
        logic [POS_BITS-1:0]  z;
    } atom_t;

    typedef struct packed {
        logic                  dup;
        logic [INDEX_BITS-1:0] match_idx;
        logic [INDEX_BITS-1:0] stored_idx;
        logic                  ovf;
    } verdict_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [TOL_BITS-1:0] cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [55:0]         s_tdata   = '0;  // atom_type, pos_x, pos_y, pos_z
    logic [0:0]          s_tuser   = '0;  // start_of_set
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;         // match_index, stored_index
    logic [1:0]          m_tuser;         // is_duplicate, overflow

    periodic_duplicate_atom_detector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Local model of the block: tolerance, atom table and fill level.
    logic [TOL_BITS-1:0] tol_model = '0;
    atom_t               atom_table [MAX_ATOMS_DEF];
    int                  fill_count = 0;

    atom_t    pending_atoms [$];   // items waiting for the driver
    atom_t    set_atoms [$];       // atoms of the set being generated, for near copies
    verdict_t verdicts_due [$];    // predicted results, oldest first
    atom_t    atom_on_bus;
    int       atoms_queued = 0;
    int       atoms_taken  = 0;
    int       mismatches   = 0;
    bit       steady_sender = 1'b0;
    int       burst_left = 1;
    int       gap_left   = 0;

    // Squared wrapped difference in Q0.(2*POS_BITS); a half cell wraps to -0.5.
    function automatic logic [2*POS_BITS+1:0] wrap_sq(logic [POS_BITS-1:0] a,
                                                       logic [POS_BITS-1:0] b);
        logic [POS_BITS-1:0] d;
        logic [POS_BITS:0]   mag;
        d   = a - b;
        mag = d[POS_BITS-1] ? ((POS_BITS+1)'(1) << POS_BITS) - {1'b0, d} : {1'b0, d};
        return {{(POS_BITS+1){1'b0}}, mag} * {{(POS_BITS+1){1'b0}}, mag};
    endfunction

    // Compare one atom against the table, report the first match, then store it.
    // With POS_BITS of 16 the distance is already Q0.32, so no alignment is needed.
    function automatic verdict_t predict_atom(atom_t a);
        verdict_t                r;
        logic [2*POS_BITS+1:0]   sq_sum;
        int                      i;
        r = '0;
        if (a.start)
            fill_count = 0;
        for (i = 0; i < fill_count && !r.dup; i++) begin
            if (atom_table[i].species == a.species) begin
                sq_sum = wrap_sq(atom_table[i].x, a.x) + wrap_sq(atom_table[i].y, a.y)
                       + wrap_sq(atom_table[i].z, a.z);
                if (sq_sum < {2'b00, tol_model}) begin
                    r.dup       = 1'b1;
                    r.match_idx = INDEX_BITS'(i);
                end
            end
        end
        if (fill_count < MAX_ATOMS_DEF) begin
            atom_table[fill_count] = a;
            r.stored_idx = INDEX_BITS'(fill_count);
            fill_count++;
        end else begin
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // Driver: offer items in bursts, hold each until the block takes it.
    always @(posedge aclk) begin : feed
        logic slot_free;
        slot_free = !s_tvalid || s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                verdicts_due.push_back(predict_atom(atom_on_bus));
                atoms_taken++;
            end
            if (slot_free) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_atoms.size() != 0) begin
                    atom_on_bus = pending_atoms.pop_front();
                    s_tdata  <= {atom_on_bus.z, atom_on_bus.y, atom_on_bus.x,
                                 atom_on_bus.species};
                    s_tuser  <= atom_on_bus.start;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        if (steady_sender)
                            gap_left = 0;
                        else if ($urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(1, 40);
                        else
                            gap_left = $urandom_range(1, 4);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a pattern that rx_clock[11:9] selects, and once
    // hold off for a long stretch so the block fills up and stalls its input.
    int rx_clock   = 0;
    int rx_taken   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_clock++;
            if (m_tvalid && m_tready)
                rx_taken++;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && rx_taken >= 600) begin
                hold_done = 1'b1;
                hold_left = 3000;
                m_tready <= 1'b0;
            end else begin
                case (rx_clock[11:9])
                    3'd0, 3'd1: m_tready <= 1'b1;
                    3'd2:       m_tready <= ($urandom_range(0, 1) == 0);
                    3'd3:       m_tready <= ($urandom_range(0, 3) == 0);
                    3'd4:       m_tready <= (rx_clock[2:0] != 3'd0);
                    3'd5:       m_tready <= rx_clock[4];
                    default:    m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Monitor: check each result against the oldest prediction, field by field.
    always @(posedge aclk) begin : check
        verdict_t want;
        verdict_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.dup        = m_tuser[0];
            got.ovf        = m_tuser[1];
            got.match_idx  = m_tdata[7:0];
            got.stored_idx = m_tdata[15:8];
            if (verdicts_due.size() == 0) begin
                $display("%0t: result with none expected, got %p", $time, got);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                if (got.dup !== want.dup) begin
                    $display("%0t: is_duplicate expected %0d got %0d", $time, want.dup, got.dup);
                    mismatches++;
                end
                if (got.match_idx !== want.match_idx) begin
                    $display("%0t: match_index expected %0d got %0d",
                             $time, want.match_idx, got.match_idx);
                    mismatches++;
                end
                if (got.stored_idx !== want.stored_idx) begin
                    $display("%0t: stored_index expected %0d got %0d",
                             $time, want.stored_idx, got.stored_idx);
                    mismatches++;
                end
                if (got.ovf !== want.ovf) begin
                    $display("%0t: overflow expected %0d got %0d", $time, want.ovf, got.ovf);
                    mismatches++;
                end
            end
        end
    end

    // Wait until every queued item is taken and every result has come back.
    task automatic drain(input int tail);
        while (atoms_taken != atoms_queued || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // Write the tolerance register; only called with the block idle.
    task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tol_model = value;
    endtask

    task automatic queue_atom(input logic start, input logic [TYPE_BITS-1:0] species,
                              input logic [POS_BITS-1:0] x, input logic [POS_BITS-1:0] y,
                              input logic [POS_BITS-1:0] z);
        atom_t a;
        a = '{start, species, x, y, z};
        pending_atoms.push_back(a);
        atoms_queued++;
    endtask

    function automatic logic [POS_BITS-1:0] jitter(int span);
        return POS_BITS'($urandom_range(0, 2 * span)) - POS_BITS'(span);
    endfunction

    // Queue one set: mostly near copies of earlier atoms or fresh atoms of a
    // few species, with some noise items that may also restart a short set.
    task automatic queue_set(input int len, input bit with_start);
        atom_t a;
        atom_t pick;
        int    k;
        int    roll;
        int    span;
        if (with_start)
            set_atoms.delete();
        for (k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            a.start = 1'b0;
            if (roll < 8) begin
                a.species = TYPE_BITS'($urandom_range(0, 255));
                a.x = POS_BITS'($urandom);
                a.y = POS_BITS'($urandom);
                a.z = POS_BITS'($urandom);
                // Keep long sets whole so the table runs past its end.
                a.start = (len < MAX_ATOMS_DEF) && ($urandom_range(0, 7) == 0);
            end else if (roll < 55 && set_atoms.size() != 0) begin
                pick = set_atoms[$urandom_range(0, set_atoms.size() - 1)];
                case ($urandom_range(0, 3))
                    0:       span = 0;
                    1:       span = 8;
                    2:       span = 64;
                    default: span = 1024;
                endcase
                a.species = pick.species;
                a.x = pick.x + jitter(span);
                a.y = pick.y + jitter(span);
                a.z = pick.z + jitter(span);
            end else begin
                a.species = TYPE_BITS'($urandom_range(0, 3));
                a.x = POS_BITS'($urandom);
                a.y = POS_BITS'($urandom);
                a.z = POS_BITS'($urandom);
            end
            if (with_start && k == 0)
                a.start = 1'b1;
            if (a.start)
                set_atoms.delete();
            set_atoms.push_back(a);
            queue_atom(a.start, a.species, a.x, a.y, a.z);
        end
    endtask

    logic [TOL_BITS-1:0] phase_tol [8];

    initial begin
        int phase;
        int items_left;
        int len;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Tolerance just above a half-cell square: one half-cell axis matches.
        write_tolerance(32'h4000_0001);
        queue_atom(1'b1, 8'd0,   16'h0000, 16'h0000, 16'h0000);
        queue_atom(1'b0, 8'd0,   16'h8000, 16'h0000, 16'h0000);
        queue_atom(1'b0, 8'd1,   16'h0000, 16'h0000, 16'h0000);
        queue_atom(1'b0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_atom(1'b0, 8'd255, 16'h0000, 16'h0000, 16'h0000);  // wraps across zero
        queue_atom(1'b0, 8'd0,   16'h8000, 16'h8000, 16'h8000);
        queue_atom(1'b1, 8'd0,   16'h0000, 16'h0000, 16'h0000);  // set restart
        drain(10);

        // Exactly the half-cell square: the strict compare must reject it.
        write_tolerance(32'h4000_0000);
        queue_atom(1'b1, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        queue_atom(1'b0, 8'd0, 16'h8000, 16'h0000, 16'h0000);
        drain(10);

        // Widest tolerance: any same-species atom matches.
        write_tolerance('1);
        queue_atom(1'b1, 8'd7, 16'h1234, 16'hABCD, 16'h8000);
        queue_atom(1'b0, 8'd7, 16'h9234, 16'h2BCD, 16'h0000);
        queue_atom(1'b0, 8'd8, 16'h1234, 16'hABCD, 16'h8000);
        drain(10);

        // Zero tolerance: even an identical atom is no match.
        write_tolerance('0);
        queue_atom(1'b1, 8'd3, 16'h5555, 16'hAAAA, 16'h0001);
        queue_atom(1'b0, 8'd3, 16'h5555, 16'hAAAA, 16'h0001);
        drain(10);

        phase_tol[0] = 32'd12288;
        phase_tol[1] = '0;
        phase_tol[2] = '1;
        phase_tol[3] = 32'd1;
        phase_tol[4] = $urandom;
        phase_tol[5] = $urandom_range(0, 1 << 16);
        phase_tol[6] = 32'h4000_0000;
        phase_tol[7] = $urandom_range(1 << 20, 1 << 24);

        for (phase = 0; phase < 8; phase++) begin
            write_tolerance(phase_tol[phase]);
            steady_sender = (phase % 3 == 1);
            items_left = 242;
            while (items_left > 0) begin
                // Fill the table past its end in two phases to reach overflow.
                if ((phase == 2 || phase == 5) && items_left == 242)
                    len = 270;
                else
                    len = $urandom_range(1, 40);
                queue_set(len, $urandom_range(0, 9) != 0);
                items_left -= len;
            end
            // Hold the sender until every result of the phase is back.
            drain(10);
        end

        drain(300);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
